[hw/rtl/trfis_pkg.sv]
// ----------------------------------------------------------------------------
// trfis_pkg
// Shared types and constants for the tick, rate flag and interval sequencer
// block.
// ----------------------------------------------------------------------------
package trfis_pkg;

   typedef enum logic [1:0] {
      KIND_TICK  = 2'd0,
      KIND_START = 2'd1,
      KIND_STOP  = 2'd2,
      KIND_LOAD  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      CSR_FAST_PERIOD = 2'd0,
      CSR_SLOW_PERIOD = 2'd1,
      CSR_SEQ_LENGTH  = 2'd2,
      CSR_UNUSED      = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic running;
      logic fired;
   } seq_status_type;

   localparam int unsigned INTERVAL_W = 16;
   localparam int unsigned SEQ_LEN_W  = 5;
   localparam int unsigned SLOT_W     = 4;
   localparam int unsigned PERIOD_W   = 16;
   localparam int unsigned UPTIME_W   = 32;

   localparam logic [PERIOD_W-1:0]   FAST_PERIOD_RESET = 16'd5;
   localparam logic [PERIOD_W-1:0]   SLOW_PERIOD_RESET = 16'd10;
   localparam logic [SEQ_LEN_W-1:0]  SEQ_LENGTH_RESET  = 5'd10;
   localparam logic [INTERVAL_W-1:0] FIRST_SLOT0_INIT  = 16'd100;
   localparam logic [INTERVAL_W-1:0] TABLE_FILL_INIT   = 16'd200;

endpackage

[hw/rtl/tick_rate_flags_and_interval_sequencers.sv]
// ----------------------------------------------------------------------------
// tick_rate_flags_and_interval_sequencers
// Millisecond tick block: uptime count, two rate dividers and two interval
// sequencers driven by tick, start, stop and table load requests.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle while its output buffer has room
// and returns one registered response per request. Each sequencer keeps its
// interval table in a small memory whose next-index word and slot 0 word are
// read ahead into registers, so that the update of countdown and index always
// finds its data ready. Responses pass through a two-entry output buffer, so a
// stalled consumer holds off the request side only after two responses have
// piled up. After reset the tables read as 100 in the first table's slot 0 and
// 200 elsewhere until written.
module tick_rate_flags_and_interval_sequencers #(
   parameter int unsigned TABLE_SLOTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // Bits from 0: load_which, load_slot[3:0], load_interval[15:0], zero pad.
   input  logic [23:0] req_tdata,
   // Bits from 0: kind[1:0].
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // Bits from 0: uptime_ticks[31:0], fast_pulse, slow_pulse, first_fired,
   // second_fired, first_running, second_running, zero pad.
   output logic [39:0] rsp_tdata,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import trfis_pkg::*;

   kind_type              kind;
   logic                  load_which;
   logic [SLOT_W-1:0]     load_slot;
   logic [INTERVAL_W-1:0] load_interval;

   logic accept, do_tick, do_start, do_stop, do_load;

   logic [PERIOD_W-1:0]  fast_period_ff, slow_period_ff;
   logic [SEQ_LEN_W-1:0] seq_len_ff;

   logic [UPTIME_W-1:0] uptime_ff, uptime_in;
   logic [PERIOD_W-1:0] fast_div_ff, fast_div_in, fast_next;
   logic [PERIOD_W-1:0] slow_div_ff, slow_div_in, slow_next;
   logic                fast_pulse, slow_pulse;

   seq_status_type first_in, second_in, first_st, second_st;

   logic [39:0] result;
   logic [39:0] out_data_ff, skid_data_ff;
   logic        out_vld_ff, skid_vld_ff;
   logic        pop;

   assign kind          = kind_type'(req_tuser);
   assign load_which    = req_tdata[0];
   assign load_slot     = req_tdata[4:1];
   assign load_interval = req_tdata[20:5];

   assign req_tready = !skid_vld_ff;
   assign accept     = req_tvalid && req_tready;
   assign do_tick    = accept && (kind == KIND_TICK);
   assign do_start   = accept && (kind == KIND_START);
   assign do_stop    = accept && (kind == KIND_STOP);
   assign do_load    = accept && (kind == KIND_LOAD);

   always_ff @(posedge clock) begin
      if (reset) begin
         fast_period_ff <= FAST_PERIOD_RESET;
         slow_period_ff <= SLOW_PERIOD_RESET;
         seq_len_ff     <= SEQ_LENGTH_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_FAST_PERIOD: fast_period_ff <= csr_wdata;
            CSR_SLOW_PERIOD: slow_period_ff <= csr_wdata;
            CSR_SEQ_LENGTH:  seq_len_ff     <= csr_wdata[SEQ_LEN_W-1:0];
            default: ;
         endcase
      end
   end

   assign fast_next = fast_div_ff + PERIOD_W'(1);
   assign slow_next = slow_div_ff + PERIOD_W'(1);

   always_comb begin
      uptime_in   = uptime_ff;
      fast_div_in = fast_div_ff;
      slow_div_in = slow_div_ff;
      fast_pulse  = 1'b0;
      slow_pulse  = 1'b0;
      if (do_tick) begin
         uptime_in = uptime_ff + UPTIME_W'(1);
         if (fast_next >= fast_period_ff) begin
            fast_div_in = '0;
            fast_pulse  = 1'b1;
         end else begin
            fast_div_in = fast_next;
         end
         if (slow_next >= slow_period_ff) begin
            slow_div_in = '0;
            slow_pulse  = 1'b1;
         end else begin
            slow_div_in = slow_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         uptime_ff   <= '0;
         fast_div_ff <= '0;
         slow_div_ff <= '0;
      end else begin
         uptime_ff   <= uptime_in;
         fast_div_ff <= fast_div_in;
         slow_div_ff <= slow_div_in;
      end
   end

   trfis_seq #(
      .TABLE_SLOTS(TABLE_SLOTS)
   ) u_first_seq (
      .clock      (clock),
      .reset      (reset),
      .step       (do_tick),
      .start      (do_start),
      .stop       (do_stop),
      .wr_en      (do_load && !load_which),
      .wr_slot    (load_slot),
      .wr_data    (load_interval),
      .seq_len    (seq_len_ff),
      .slot0_init (FIRST_SLOT0_INIT),
      .status_in  (first_in),
      .status     (first_st)
   );

   trfis_seq #(
      .TABLE_SLOTS(TABLE_SLOTS)
   ) u_second_seq (
      .clock      (clock),
      .reset      (reset),
      .step       (do_tick),
      .start      (do_start),
      .stop       (do_stop),
      .wr_en      (do_load && load_which),
      .wr_slot    (load_slot),
      .wr_data    (load_interval),
      .seq_len    (seq_len_ff),
      .slot0_init (TABLE_FILL_INIT),
      .status_in  (second_in),
      .status     (second_st)
   );

   assign result = {2'b00, second_in.running, first_in.running, second_in.fired,
                    first_in.fired, slow_pulse, fast_pulse, uptime_in};

   assign pop = out_vld_ff && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         if (pop) begin
            if (skid_vld_ff) begin
               skid_vld_ff <= 1'b0;
            end else begin
               out_vld_ff <= accept;
            end
         end else if (accept) begin
            if (out_vld_ff) begin
               skid_vld_ff <= 1'b1;
            end else begin
               out_vld_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop && skid_vld_ff) begin
         out_data_ff <= skid_data_ff;
      end else if (accept && (!out_vld_ff || pop)) begin
         out_data_ff <= result;
      end
      if (accept && out_vld_ff && !pop) begin
         skid_data_ff <= result;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> out_vld_ff)
      else $error("Skid entry held while the output register is empty.");

   a_uptime_step: assert property (@(posedge clock) disable iff (reset)
      do_tick |=> uptime_ff == $past(uptime_ff) + UPTIME_W'(1))
      else $error("Uptime count did not advance on a tick request.");

   a_stop_clears: assert property (@(posedge clock) disable iff (reset)
      do_stop |=> !first_st.running && !second_st.running &&
                  !first_st.fired && !second_st.fired)
      else $error("Stop request left a sequencer running or fired.");

endmodule

[hw/rtl/trfis_seq.sv]
// ----------------------------------------------------------------------------
// trfis_seq
// One interval sequencer: its interval table in a memory, countdown, index,
// run and fire flags. The word at the next index and slot 0 are prefetched
// every cycle, with bypass of a table write made in the same cycle.
// ----------------------------------------------------------------------------
module trfis_seq #(
   parameter int unsigned TABLE_SLOTS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 step,
   input  logic                                 start,
   input  logic                                 stop,
   input  logic                                 wr_en,
   input  logic [trfis_pkg::SLOT_W-1:0]         wr_slot,
   input  logic [trfis_pkg::INTERVAL_W-1:0]     wr_data,
   input  logic [trfis_pkg::SEQ_LEN_W-1:0]      seq_len,
   input  logic [trfis_pkg::INTERVAL_W-1:0]     slot0_init,
   output trfis_pkg::seq_status_type            status_in,
   output trfis_pkg::seq_status_type            status
);
   import trfis_pkg::*;

   localparam int unsigned ADDR_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int unsigned IDX_W  = $clog2(TABLE_SLOTS + 1);
   localparam int unsigned CMP_W  = (IDX_W > SEQ_LEN_W) ? IDX_W : SEQ_LEN_W;
   localparam int unsigned SEL_W  = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

   logic [INTERVAL_W-1:0] mem [TABLE_SLOTS];
   logic [TABLE_SLOTS-1:0] valid_ff;

   logic [INTERVAL_W-1:0] countdown_ff, countdown_in;
   logic [IDX_W-1:0]      index_ff, index_in;
   logic                  running_ff, running_in;
   logic                  fired_ff, fired_in;

   logic [INTERVAL_W-1:0] idx_word_ff, zero_word_ff, byp_data_ff;
   logic                  idx_byp_ff, zero_byp_ff, idx_vld_ff, zero_vld_ff, idx_is0_ff;
   logic [INTERVAL_W-1:0] idx_data, zero_data;

   logic [SEL_W-1:0]  slot_ext;
   logic              wr_ok;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic              can_advance;

   assign slot_ext = SEL_W'(wr_slot);
   assign wr_ok    = wr_en && (slot_ext < SEL_W'(TABLE_SLOTS));
   assign wr_addr  = slot_ext[ADDR_W-1:0];
   assign rd_addr  = (index_in < IDX_W'(TABLE_SLOTS)) ? index_in[ADDR_W-1:0] : '0;

   always_ff @(posedge clock) begin
      if (wr_ok) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_ok) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      idx_word_ff  <= mem[rd_addr];
      zero_word_ff <= mem[0];
      byp_data_ff  <= wr_data;
      idx_is0_ff   <= (rd_addr == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_byp_ff  <= 1'b0;
         zero_byp_ff <= 1'b0;
         idx_vld_ff  <= 1'b0;
         zero_vld_ff <= 1'b0;
      end else begin
         idx_byp_ff  <= wr_ok && (wr_addr == rd_addr);
         zero_byp_ff <= wr_ok && (wr_addr == '0);
         idx_vld_ff  <= valid_ff[rd_addr];
         zero_vld_ff <= valid_ff[0];
      end
   end

   // An entry never written reads as its reset value.
   assign idx_data  = idx_byp_ff ? byp_data_ff :
                      idx_vld_ff ? idx_word_ff :
                      idx_is0_ff ? slot0_init : TABLE_FILL_INIT;
   assign zero_data = zero_byp_ff ? byp_data_ff :
                      zero_vld_ff ? zero_word_ff : slot0_init;

   assign can_advance = (CMP_W'(index_ff) < CMP_W'(seq_len)) &&
                        (index_ff < IDX_W'(TABLE_SLOTS));

   always_comb begin
      countdown_in = countdown_ff;
      index_in     = index_ff;
      running_in   = running_ff;
      fired_in     = fired_ff;
      if (step && running_ff) begin
         if (countdown_ff != '0) begin
            countdown_in = countdown_ff - INTERVAL_W'(1);
         end else begin
            fired_in = 1'b1;
            if (can_advance) begin
               countdown_in = idx_data;
               index_in     = index_ff + IDX_W'(1);
            end else begin
               running_in = 1'b0;
            end
         end
      end else if (start) begin
         countdown_in = zero_data;
         running_in   = 1'b1;
      end else if (stop) begin
         countdown_in = zero_data;
         running_in   = 1'b0;
         fired_in     = 1'b0;
         index_in     = IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         countdown_ff <= '0;
         index_ff     <= IDX_W'(1);
         running_ff   <= 1'b0;
         fired_ff     <= 1'b0;
      end else begin
         countdown_ff <= countdown_in;
         index_ff     <= index_in;
         running_ff   <= running_in;
         fired_ff     <= fired_in;
      end
   end

   assign status_in.running = running_in;
   assign status_in.fired   = fired_in;
   assign status.running    = running_ff;
   assign status.fired      = fired_ff;

endmodule

[tb/tb_tick_rate_flags_and_interval_sequencers.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tick_rate_flags_and_interval_sequencers
// Streams tick, start, stop and table load requests into the block. A
// scoreboard keeps its own copy of the uptime count, the rate dividers and
// both interval sequencers. It predicts the status response of each request
// and checks every response against it field by field. Register settings
// change between bursts while the block is idle. Both stream sides stall at
// random, and once the response side holds off long enough that the request
// side backs up.
// ----------------------------------------------------------------------------
module tb_tick_rate_flags_and_interval_sequencers;
   import trfis_pkg::*;

   localparam int unsigned SLOTS           = 16;
   localparam int unsigned QUIET_LIMIT     = 1000;
   localparam int unsigned HOLD_OFF_CYCLES = 80;
   localparam int unsigned BURST_ITEMS     = 100;
   localparam int unsigned BURST_COUNT     = 9;

   typedef struct packed {
      logic                second_running;
      logic                first_running;
      logic                second_fired;
      logic                first_fired;
      logic                slow_pulse;
      logic                fast_pulse;
      logic [UPTIME_W-1:0] uptime_ticks;
   } tick_status_type;

   class tick_sequencer_scoreboard;
      logic [PERIOD_W-1:0]   period [2];
      logic [PERIOD_W-1:0]   divider [2];
      logic [SEQ_LEN_W-1:0]  seq_length;
      logic [UPTIME_W-1:0]   uptime;
      logic [INTERVAL_W-1:0] intervals [2][SLOTS];
      logic [INTERVAL_W-1:0] countdown [2];
      logic [SEQ_LEN_W-1:0]  slot_index [2];
      bit                    running [2];
      bit                    fired [2];
      tick_status_type       expected_status_q [$];
      int unsigned           errors;

      function new();
         period[0]  = FAST_PERIOD_RESET;
         period[1]  = SLOW_PERIOD_RESET;
         seq_length = SEQ_LENGTH_RESET;
         uptime     = '0;
         errors     = 0;
         for (int k = 0; k < 2; k++) begin
            divider[k]    = '0;
            countdown[k]  = '0;
            slot_index[k] = 1;
            running[k]    = 1'b0;
            fired[k]      = 1'b0;
            for (int s = 0; s < SLOTS; s++) intervals[k][s] = TABLE_FILL_INIT;
         end
         intervals[0][0] = FIRST_SLOT0_INIT;
      endfunction

      function void write_register(csr_index_type idx, logic [15:0] value);
         case (idx)
            CSR_FAST_PERIOD: period[0] = value;
            CSR_SLOW_PERIOD: period[1] = value;
            CSR_SEQ_LENGTH:  seq_length = value[SEQ_LEN_W-1:0];
            default: ;
         endcase
      endfunction

      function void take_request(kind_type kind, logic [23:0] data);
         logic                  which;
         logic [SLOT_W-1:0]     slot;
         logic [INTERVAL_W-1:0] interval;
         logic [PERIOD_W-1:0]   next_count;
         bit                    pulse [2];
         int unsigned           limit;
         tick_status_type       status;
         which    = data[0];
         slot     = data[4:1];
         interval = data[20:5];
         pulse[0] = 1'b0;
         pulse[1] = 1'b0;
         limit    = (seq_length > SLOTS) ? SLOTS : seq_length;
         case (kind)
            KIND_TICK: begin
               uptime = uptime + 1'b1;
               for (int d = 0; d < 2; d++) begin
                  next_count = divider[d] + 16'd1;
                  if (next_count >= period[d]) begin
                     divider[d] = '0;
                     pulse[d]   = 1'b1;
                  end else begin
                     divider[d] = next_count;
                  end
               end
               for (int k = 0; k < 2; k++) begin
                  if (running[k]) begin
                     if (countdown[k] != 0) begin
                        countdown[k] = countdown[k] - 1'b1;
                     end else begin
                        fired[k] = 1'b1;
                        if (slot_index[k] < limit) begin
                           countdown[k]  = intervals[k][slot_index[k]];
                           slot_index[k] = slot_index[k] + 1'b1;
                        end else begin
                           running[k] = 1'b0;
                        end
                     end
                  end
               end
            end
            KIND_START: begin
               for (int k = 0; k < 2; k++) begin
                  countdown[k] = intervals[k][0];
                  running[k]   = 1'b1;
               end
            end
            KIND_STOP: begin
               for (int k = 0; k < 2; k++) begin
                  running[k]    = 1'b0;
                  fired[k]      = 1'b0;
                  slot_index[k] = 1;
                  countdown[k]  = intervals[k][0];
               end
            end
            default: begin
               intervals[which][slot] = interval;
            end
         endcase
         status.uptime_ticks   = uptime;
         status.fast_pulse     = pulse[0];
         status.slow_pulse     = pulse[1];
         status.first_fired    = fired[0];
         status.second_fired   = fired[1];
         status.first_running  = running[0];
         status.second_running = running[1];
         expected_status_q.push_back(status);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_status(logic [39:0] word);
         tick_status_type want;
         tick_status_type got;
         if (expected_status_q.size() == 0) begin
            $error("status response with no request waiting: %h", word);
            errors++;
            return;
         end
         want = expected_status_q.pop_front();
         got  = word[37:0];
         compare_field("uptime_ticks", want.uptime_ticks, got.uptime_ticks);
         compare_field("fast_pulse", want.fast_pulse, got.fast_pulse);
         compare_field("slow_pulse", want.slow_pulse, got.slow_pulse);
         compare_field("first_fired", want.first_fired, got.first_fired);
         compare_field("second_fired", want.second_fired, got.second_fired);
         compare_field("first_running", want.first_running, got.first_running);
         compare_field("second_running", want.second_running, got.second_running);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic [1:0]  req_tuser = KIND_TICK;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_index = CSR_FAST_PERIOD;
   logic [15:0] csr_wdata = '0;

   int unsigned send_idle_pct = 0;
   int unsigned rsp_idle_pct = 0;
   bit          hold_off_go = 1'b0;

   tick_sequencer_scoreboard board = new();

   tick_rate_flags_and_interval_sequencers dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_wr_en) board.write_register(csr_index_type'(csr_index), csr_wdata);
         if (rsp_tvalid && rsp_tready) board.check_status(rsp_tdata);
         if (req_tvalid && req_tready) board.take_request(kind_type'(req_tuser), req_tdata);
      end
   end

   initial begin : rsp_driver
      forever begin
         @(posedge clock);
         if (hold_off_go) begin
            hold_off_go = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   initial begin : watchdog
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("Regression FAIL");
      $finish;
   end

   // Valid stays high between requests, bar idle gaps; end_burst lowers it.
   task automatic send_request(kind_type kind, logic which, logic [3:0] slot,
                               logic [15:0] interval);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {3'b000, interval, slot, which};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic end_burst();
      req_tvalid <= 1'b0;
   endtask

   task automatic write_register(csr_index_type idx, logic [15:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic wait_idle();
      @(posedge clock);
      while (board.expected_status_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic send_random_item();
      int unsigned roll;
      logic [15:0] interval;
      roll     = $urandom_range(99);
      interval = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(6));
      if (roll < 68) begin
         send_request(KIND_TICK, 1'($urandom), 4'($urandom), 16'($urandom));
      end else if (roll < 86) begin
         send_request(KIND_LOAD, 1'($urandom), 4'($urandom), interval);
      end else if (roll < 93) begin
         send_request(KIND_START, 1'($urandom), 4'($urandom), 16'($urandom));
      end else begin
         send_request(KIND_STOP, 1'($urandom), 4'($urandom), 16'($urandom));
      end
   endtask

   // Short intervals are loaded and the sequencers started, so that they run
   // through several slots within the burst where the sequence length allows.
   task automatic run_burst(logic [15:0] fast, logic [15:0] slow, logic [15:0] length_word);
      wait_idle();
      write_register(CSR_FAST_PERIOD, fast);
      write_register(CSR_SLOW_PERIOD, slow);
      write_register(CSR_SEQ_LENGTH, length_word);
      csr_wr_en <= 1'b0;
      for (int s = 0; s < 4; s++) begin
         send_request(KIND_LOAD, 1'b0, 4'(s), 16'($urandom_range(4)));
         send_request(KIND_LOAD, 1'b1, 4'(s), 16'($urandom_range(4)));
      end
      send_request(KIND_START, 1'b0, 4'd0, 16'd0);
      for (int i = 0; i < BURST_ITEMS - 9; i++) send_random_item();
      end_burst();
   endtask

   initial begin : stimulus
      logic [15:0] fast;
      logic [15:0] slow;
      logic [15:0] length_word;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 10;
      rsp_idle_pct  = 55;
      send_request(KIND_TICK, 1'b1, 4'hF, 16'hFFFF);
      send_request(KIND_LOAD, 1'b0, 4'd0, 16'd0);
      send_request(KIND_LOAD, 1'b0, 4'd1, 16'd2);
      send_request(KIND_LOAD, 1'b1, 4'd0, 16'd3);
      send_request(KIND_LOAD, 1'b1, 4'd1, 16'd0);
      send_request(KIND_LOAD, 1'b1, 4'hF, 16'hFFFF);
      send_request(KIND_LOAD, 1'b0, 4'hF, 16'd0);
      send_request(KIND_START, 1'b0, 4'd0, 16'd0);
      repeat (8) send_request(KIND_TICK, 1'b0, 4'd0, 16'd0);
      send_request(KIND_START, 1'b1, 4'hF, 16'hFFFF);
      repeat (3) send_request(KIND_TICK, 1'b0, 4'd0, 16'd0);
      send_request(KIND_STOP, 1'b0, 4'd0, 16'd0);
      send_request(KIND_TICK, 1'b0, 4'd0, 16'd0);
      send_request(KIND_START, 1'b0, 4'd0, 16'd0);
      send_request(KIND_TICK, 1'b0, 4'd0, 16'd0);
      end_burst();

      for (int p = 0; p < BURST_COUNT; p++) begin
         if (p < 3) begin
            send_idle_pct = 10;
            rsp_idle_pct  = 55;
         end else if (p < 6) begin
            send_idle_pct = 55;
            rsp_idle_pct  = 10;
         end else begin
            send_idle_pct = 0;
            rsp_idle_pct  = 0;
         end
         case (p)
            0: begin
               fast = 16'd0;
               slow = 16'd0;
               length_word = 16'd0;
            end
            1: begin
               fast = 16'd1;
               slow = 16'hFFFF;
               length_word = 16'd1;
            end
            2: begin
               fast = 16'hFFFF;
               slow = 16'd1;
               length_word = 16'd16;
            end
            3: begin
               fast = 16'd3;
               slow = 16'd7;
               length_word = {11'($urandom), 5'd31};
            end
            default: begin
               fast = 16'($urandom_range(1, 12));
               slow = 16'($urandom_range(1, 20));
               length_word = 16'($urandom_range(0, 31));
            end
         endcase
         if (p == 4) begin
            wait_idle();
            write_register(CSR_UNUSED, 16'($urandom));
            csr_wr_en <= 1'b0;
            hold_off_go = 1'b1;
         end
         run_burst(fast, slow, length_word);
      end

      @(posedge clock);
      while (board.expected_status_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (board.errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

[files.f]
hw/rtl/trfis_pkg.sv
hw/rtl/trfis_seq.sv
hw/rtl/tick_rate_flags_and_interval_sequencers.sv
tb/tb_tick_rate_flags_and_interval_sequencers.sv
